>>> sv/sqmm_pkg.sv
`timescale 1ns / 1ps

package sqmm_pkg;

   // Sizing
   localparam int MAX_SIZE       = 8;
   localparam int ELEMENT_BITS   = 16;

   // Port widths
   localparam int KIND_BITS      = 2;
   localparam int INDEX_BITS     = 3;
   localparam int INPUT_BITS     = 16;
   localparam int PRODUCT_BITS   = 35;
   localparam int SIZE_BITS      = 4;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(MAX_SIZE);

   // Derived widths
   localparam int CNT_BITS       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int MEM_DEPTH      = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_BITS      = $clog2(MEM_DEPTH);
   localparam int MULT_BITS      = 2 * ELEMENT_BITS;
   localparam int ELEM_WIDE_BITS = (INPUT_BITS > ELEMENT_BITS) ? INPUT_BITS : ELEMENT_BITS;
   localparam int SUM_WIDE_BITS  = (MULT_BITS > PRODUCT_BITS) ? MULT_BITS : PRODUCT_BITS;

   // Command queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

   // Input kind codes
   localparam logic [KIND_BITS-1:0] KIND_LOAD_A  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LOAD_B  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_COMPUTE = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD_A,
      OP_LOAD_B,
      OP_COMPUTE
   } op_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   typedef struct packed {
      op_type                         op;
      logic [ADDR_BITS-1:0]           addr;
      logic signed [ELEMENT_BITS-1:0] value;
   } queue_entry_type;

endpackage

>>> sv/sqmm_front.sv
`timescale 1ns / 1ps

module sqmm_front (
   input  logic                                push,
   input  logic                                full,
   input  logic [sqmm_pkg::KIND_BITS-1:0]      req_kind,
   input  logic [sqmm_pkg::INDEX_BITS-1:0]     req_row_index,
   input  logic [sqmm_pkg::INDEX_BITS-1:0]     req_col_index,
   input  logic signed [sqmm_pkg::INPUT_BITS-1:0] req_element_value,
   output logic                                queue_push,
   output sqmm_pkg::queue_entry_type           queue_entry
);
   import sqmm_pkg::*;

   localparam logic [INDEX_BITS:0] INDEX_LIMIT = (INDEX_BITS + 1)'(MAX_SIZE);

   logic                             accept;
   logic                             in_range;
   logic                             keep;
   logic signed [ELEM_WIDE_BITS-1:0] wide_value;

   assign accept     = push && !full;
   assign in_range   = ({1'b0, req_row_index} < INDEX_LIMIT) &&
                       ({1'b0, req_col_index} < INDEX_LIMIT);
   assign wide_value = req_element_value;

   // Classify: out-of-range writes and the unused kind are dropped here
   always_comb begin
      keep              = 1'b0;
      queue_entry.op    = OP_COMPUTE;
      queue_entry.addr  = ADDR_BITS'(req_row_index * MAX_SIZE + req_col_index);
      queue_entry.value = wide_value[ELEMENT_BITS-1:0];
      case (req_kind)
         KIND_LOAD_A: begin
            keep           = in_range;
            queue_entry.op = OP_LOAD_A;
         end
         KIND_LOAD_B: begin
            keep           = in_range;
            queue_entry.op = OP_LOAD_B;
         end
         KIND_COMPUTE: begin
            keep           = 1'b1;
            queue_entry.op = OP_COMPUTE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign queue_push = accept && keep;

endmodule

>>> sv/sqmm_queue.sv
`timescale 1ns / 1ps

module sqmm_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sqmm_pkg::queue_entry_type   push_entry,
   input  logic                        pop,
   output sqmm_pkg::queue_entry_type   pop_entry,
   output logic                        full,
   output logic                        empty
);
   import sqmm_pkg::*;

   queue_entry_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> sv/sqmm_back.sv
`timescale 1ns / 1ps

module sqmm_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [sqmm_pkg::SIZE_BITS-1:0]         matrix_size,
   input  logic                                   queue_empty,
   input  sqmm_pkg::queue_entry_type              queue_entry,
   output logic                                   queue_pop,
   output logic                                   empty,
   input  logic                                   pop,
   output logic [sqmm_pkg::INDEX_BITS-1:0]        rsp_out_row,
   output logic [sqmm_pkg::INDEX_BITS-1:0]        rsp_out_col,
   output logic signed [sqmm_pkg::PRODUCT_BITS-1:0] rsp_product_value,
   output logic                                   rsp_last_result
);
   import sqmm_pkg::*;

   // Element stores, one read port each
   logic signed [ELEMENT_BITS-1:0] matrix_a_ff [MEM_DEPTH];
   logic signed [ELEMENT_BITS-1:0] matrix_b_ff [MEM_DEPTH];

   back_state_type state_ff, state_in;

   logic [CNT_BITS-1:0] n_last_ff, n_last_in;
   logic [CNT_BITS-1:0] i_ff, i_in;
   logic [CNT_BITS-1:0] j_ff, j_in;
   logic [CNT_BITS-1:0] k_ff, k_in;

   logic                start;
   logic                issue;
   logic                advance;
   logic                k_end, j_end, i_end;
   logic                write_a, write_b;
   logic [ADDR_BITS-1:0] addr_a, addr_b;

   // Stage 1: read data and tags
   logic signed [ELEMENT_BITS-1:0] a_rd_ff, b_rd_ff;
   logic                  s1_valid_ff;
   logic                  s1_first_ff, s1_end_ff, s1_last_ff;
   logic [CNT_BITS-1:0]   s1_row_ff, s1_col_ff;

   // Stage 2: product and tags
   logic signed [MULT_BITS-1:0] prod_ff;
   logic                  s2_valid_ff;
   logic                  s2_first_ff, s2_end_ff, s2_last_ff;
   logic [CNT_BITS-1:0]   s2_row_ff, s2_col_ff;

   // Stage 3: accumulator and output register
   logic signed [SUM_WIDE_BITS-1:0] prod_wide;
   logic signed [PRODUCT_BITS-1:0]  acc_ff, acc_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_load;

   assign advance = !out_valid_ff || pop;
   assign k_end   = (k_ff == n_last_ff);
   assign j_end   = (j_ff == n_last_ff);
   assign i_end   = (i_ff == n_last_ff);
   assign addr_a  = ADDR_BITS'(i_ff * MAX_SIZE + k_ff);
   assign addr_b  = ADDR_BITS'(k_ff * MAX_SIZE + j_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!queue_empty && queue_entry.op == OP_COMPUTE) begin
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (advance && k_end && j_end && i_end) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      queue_pop = 1'b0;
      start     = 1'b0;
      issue     = 1'b0;
      write_a   = 1'b0;
      write_b   = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            queue_pop = !queue_empty;
            write_a   = !queue_empty && queue_entry.op == OP_LOAD_A;
            write_b   = !queue_empty && queue_entry.op == OP_LOAD_B;
            start     = !queue_empty && queue_entry.op == OP_COMPUTE;
         end
         BACK_RUN: begin
            issue = advance;
         end
         default: begin
            queue_pop = 1'b0;
         end
      endcase
   end

   // Size clamp and loop counters
   always_comb begin
      n_last_in = n_last_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      if (start) begin
         if (matrix_size == '0) begin
            n_last_in = '0;
         end else if (matrix_size > SIZE_BITS'(MAX_SIZE)) begin
            n_last_in = CNT_BITS'(MAX_SIZE - 1);
         end else begin
            n_last_in = CNT_BITS'(matrix_size - 1'b1);
         end
         i_in = '0;
         j_in = '0;
         k_in = '0;
      end else if (issue) begin
         if (!k_end) begin
            k_in = k_ff + 1'b1;
         end else begin
            k_in = '0;
            if (!j_end) begin
               j_in = j_ff + 1'b1;
            end else begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BACK_IDLE;
      end else begin
         state_ff  <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_last_ff <= n_last_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
   end

   // Stores: write on load, registered read whenever the pipeline advances
   always_ff @(posedge clock) begin
      if (write_a) begin
         matrix_a_ff[queue_entry.addr] <= queue_entry.value;
      end
      if (advance) begin
         a_rd_ff <= matrix_a_ff[addr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (write_b) begin
         matrix_b_ff[queue_entry.addr] <= queue_entry.value;
      end
      if (advance) begin
         b_rd_ff <= matrix_b_ff[addr_b];
      end
   end

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            s1_valid_ff <= issue;
            s2_valid_ff <= s1_valid_ff;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_first_ff <= (k_ff == '0);
         s1_end_ff   <= k_end;
         s1_last_ff  <= i_end && j_end;
         s1_row_ff   <= i_ff;
         s1_col_ff   <= j_ff;
         prod_ff     <= a_rd_ff * b_rd_ff;
         s2_first_ff <= s1_first_ff;
         s2_end_ff   <= s1_end_ff;
         s2_last_ff  <= s1_last_ff;
         s2_row_ff   <= s1_row_ff;
         s2_col_ff   <= s1_col_ff;
      end
   end

   // Accumulate; sum wraps at the result width
   assign prod_wide = SUM_WIDE_BITS'(prod_ff);
   assign acc_in    = s2_first_ff ? prod_wide[PRODUCT_BITS-1:0]
                                  : acc_ff + prod_wide[PRODUCT_BITS-1:0];
   assign out_load  = advance && s2_valid_ff && s2_end_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (out_load) begin
         rsp_product_value <= acc_in;
         rsp_out_row       <= INDEX_BITS'(s2_row_ff);
         rsp_out_col       <= INDEX_BITS'(s2_col_ff);
         rsp_last_result   <= s2_last_ff;
      end
   end

   assign empty = !out_valid_ff;

endmodule

>>> sv/square_matrix_multiply.sv
`timescale 1ns / 1ps

// Square matrix multiplier, C = A * B for n by n signed matrices (n = 1..8).
// Input queue (push/full): req_kind 0 writes A[row][col], 1 writes B[row][col],
//   2 starts a product run; kind 3 and writes outside the array are dropped.
// Result queue (empty/pop): one item per C element in row-major order, with
//   row, column, 35-bit exact dot product, and a flag on the run's last item.
// csr_write_enable/csr_write_data set n; 0 acts as 1, above 8 acts as 8.
//   Write it only while no item is in flight. Reset value is 8.
// Timing: accepted items go through a 4-entry command queue; an idle execute
//   side takes the head in the cycle after it is accepted, and a load is written
//   in that cycle. A product run then issues one multiply-accumulate per
//   cycle while no result is held, n cubed in all. Each result is built in
//   the single MAC pipeline (store read, multiply, accumulate); items behind
//   a run wait in the queue until its last issue.
// Stall: while a result is held and pop is low the MAC pipeline freezes;
//   full rises once the command queue fills.
// Reset clears the queue, pipeline and result flag; matrix stores are not
//   cleared and must be written before they are used.
module square_matrix_multiply (
   input  logic                                    clock,
   input  logic                                    reset,
   // input item channel
   input  logic                                    push,
   output logic                                    full,
   input  logic [sqmm_pkg::KIND_BITS-1:0]          req_kind,
   input  logic [sqmm_pkg::INDEX_BITS-1:0]         req_row_index,
   input  logic [sqmm_pkg::INDEX_BITS-1:0]         req_col_index,
   input  logic signed [sqmm_pkg::INPUT_BITS-1:0]  req_element_value,
   // result item channel
   output logic                                    empty,
   input  logic                                    pop,
   output logic [sqmm_pkg::INDEX_BITS-1:0]         rsp_out_row,
   output logic [sqmm_pkg::INDEX_BITS-1:0]         rsp_out_col,
   output logic signed [sqmm_pkg::PRODUCT_BITS-1:0] rsp_product_value,
   output logic                                    rsp_last_result,
   // configuration
   input  logic                                    csr_write_enable,
   input  logic [sqmm_pkg::SIZE_BITS-1:0]          csr_write_data
);
   import sqmm_pkg::*;

   logic [SIZE_BITS-1:0] matrix_size_ff, matrix_size_in;

   logic            queue_push;
   logic            queue_pop;
   logic            queue_empty;
   queue_entry_type push_entry;
   queue_entry_type pop_entry;

   // Matrix size register
   assign matrix_size_in = csr_write_enable ? csr_write_data : matrix_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_size_ff <= SIZE_RESET;
      end else begin
         matrix_size_ff <= matrix_size_in;
      end
   end

   // Front: accept and classify
   sqmm_front u_front (
      .push              (push),
      .full              (full),
      .req_kind          (req_kind),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .queue_push        (queue_push),
      .queue_entry       (push_entry)
   );

   // Command queue; full backs up onto the input channel
   sqmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .pop        (queue_pop),
      .pop_entry  (pop_entry),
      .full       (full),
      .empty      (queue_empty)
   );

   // Back: stores and MAC pipeline
   sqmm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .matrix_size       (matrix_size_ff),
      .queue_empty       (queue_empty),
      .queue_entry       (pop_entry),
      .queue_pop         (queue_pop),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

>>> tb/square_matrix_multiply_test.sv
`timescale 1ns / 1ps

module square_matrix_multiply_test;
   import sqmm_pkg::*;

   // kind 3 has no name in the package; the block drops it
   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
   localparam int CELLS        = MAX_SIZE * MAX_SIZE;
   // settle time after the last result before a size change or the end;
   // covers loads still draining out of the command queue
   localparam int SETTLE_CYCLES = 64;
   // worst case: every item a full 8x8 run with a stalled receiver, padded
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int PHASE_ITEMS   = 13;

   typedef struct {
      logic [KIND_BITS-1:0]         kind;
      logic [INDEX_BITS-1:0]        row;
      logic [INDEX_BITS-1:0]        col;
      logic signed [INPUT_BITS-1:0] value;
   } request_type;

   typedef struct {
      logic [INDEX_BITS-1:0]          row;
      logic [INDEX_BITS-1:0]          col;
      logic signed [PRODUCT_BITS-1:0] value;
      logic                           last;
   } product_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            push = 1'b0;
   logic                            full;
   logic [KIND_BITS-1:0]            req_kind = '0;
   logic [INDEX_BITS-1:0]           req_row_index = '0;
   logic [INDEX_BITS-1:0]           req_col_index = '0;
   logic signed [INPUT_BITS-1:0]    req_element_value = '0;
   logic                            empty;
   logic                            pop = 1'b0;
   logic [INDEX_BITS-1:0]           rsp_out_row;
   logic [INDEX_BITS-1:0]           rsp_out_col;
   logic signed [PRODUCT_BITS-1:0]  rsp_product_value;
   logic                            rsp_last_result;
   logic                            csr_write_enable = 1'b0;
   logic [SIZE_BITS-1:0]            csr_write_data = '0;

   square_matrix_multiply u_top (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_kind          (req_kind),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last_result   (rsp_last_result),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   // items waiting to be pushed, and product elements waiting to come out
   request_type pending_items[$];
   product_type expected_products[$];

   // predictor copy of the block: both stores and the size register
   logic signed [ELEMENT_BITS-1:0] a_elems [CELLS];
   logic signed [ELEMENT_BITS-1:0] b_elems [CELLS];
   logic [SIZE_BITS-1:0]           size_setting = SIZE_RESET;

   // stimulus side bookkeeping: which cells the generator has already loaded,
   // so no compute ever touches a cell the block never saw written
   bit a_loaded [CELLS];
   bit b_loaded [CELLS];
   int gen_size = MAX_SIZE;

   // size settings of the random phases, in order
   logic [SIZE_BITS-1:0] phase_sizes [11] = '{3, 1, 2, 15, 4, 0, 5, 8, 6, 9, 7};

   int  send_idle_pct = 29;
   int  recv_idle_pct = 72;
   bit  item_taken = 1'b0;
   int  cycle_count = 0;
   int  error_count = 0;
   int  accepted_items = 0;
   int  compute_count = 0;
   int  checked_results = 0;
   int  size_changes = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d products outstanding",
                  cycle_count, expected_products.size());
         $display("square_matrix_multiply regression: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      // keep the log readable if something goes badly wrong
      if (error_count <= 40)
         $display("mismatch @%0d: %s", cycle_count, what);
   endtask

   // size register value to matrix dimension: 0 acts as 1, above 8 as 8
   function automatic int effective_size(input logic [SIZE_BITS-1:0] setting);
      if (setting == 0)
         return 1;
      if (setting > MAX_SIZE)
         return MAX_SIZE;
      return int'(setting);
   endfunction

   // Predictor: a load updates a store cell, a compute queues all n*n
   // products in row-major order, anything else changes nothing.
   task automatic predict_item(input request_type item);
      int          n;
      longint      acc;
      product_type elem;
      n = effective_size(size_setting);
      case (item.kind)
         KIND_LOAD_A: begin
            a_elems[{item.row, item.col}] = item.value;
         end
         KIND_LOAD_B: begin
            b_elems[{item.row, item.col}] = item.value;
         end
         KIND_COMPUTE: begin
            compute_count++;
            for (int i = 0; i < n; i++) begin
               for (int j = 0; j < n; j++) begin
                  acc = 0;
                  // full 64-bit sum, then keep the low 35 bits like the port
                  for (int k = 0; k < n; k++)
                     acc += longint'(a_elems[i * MAX_SIZE + k]) *
                            longint'(b_elems[k * MAX_SIZE + j]);
                  elem.row   = INDEX_BITS'(i);
                  elem.col   = INDEX_BITS'(j);
                  elem.value = acc[PRODUCT_BITS-1:0];
                  elem.last  = (i == n - 1) && (j == n - 1);
                  expected_products.push_back(elem);
               end
            end
         end
         default: begin
            // unused kind: dropped by the block
         end
      endcase
   endtask

   // Input side monitor: an item moves on push && !full. The predictor runs
   // on exactly what was accepted; size writes are tracked here too.
   always @(posedge clock) begin
      item_taken <= !reset && push && !full;
      if (!reset) begin
         if (csr_write_enable)
            size_setting = csr_write_data;
         if (push && !full) begin
            predict_item(pending_items.pop_front());
            accepted_items++;
         end
      end
   end

   // Driver: presents the head of pending_items at the falling edge. An
   // offer that was not taken stays up unchanged until it is.
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (push && !item_taken) begin
         // still offering the same item
      end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         push              <= 1'b1;
         req_kind          <= pending_items[0].kind;
         req_row_index     <= pending_items[0].row;
         req_col_index     <= pending_items[0].col;
         req_element_value <= pending_items[0].value;
      end else begin
         push <= 1'b0;
      end
   end

   // Receiver: random pop, independent of whether anything is waiting
   always @(negedge clock) begin
      pop <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Result monitor: every popped item is checked against the oldest product
   always @(posedge clock) begin
      product_type want;
      if (!reset && pop && !empty) begin
         if (expected_products.size() == 0) begin
            report_mismatch($sformatf("unexpected product (%0d,%0d) = %0d",
                                      rsp_out_row, rsp_out_col, rsp_product_value));
         end else begin
            want = expected_products.pop_front();
            checked_results++;
            if (rsp_out_row !== want.row)
               report_mismatch($sformatf("row %0d, want %0d", rsp_out_row, want.row));
            if (rsp_out_col !== want.col)
               report_mismatch($sformatf("col %0d, want %0d", rsp_out_col, want.col));
            if (rsp_product_value !== want.value)
               report_mismatch($sformatf("C[%0d][%0d] = %0d, want %0d", want.row, want.col,
                                         rsp_product_value, want.value));
            if (rsp_last_result !== want.last)
               report_mismatch($sformatf("last flag %b at (%0d,%0d), want %b",
                                         rsp_last_result, want.row, want.col, want.last));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------

   // half corner values, the rest uniform over 16 bits
   function automatic logic signed [INPUT_BITS-1:0] pick_element();
      case ($urandom_range(7))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return '0;
         3:       return '1;
         default: return INPUT_BITS'($urandom);
      endcase
   endfunction

   // favor cells inside the active n x n window, but touch the rest too
   function automatic logic [INDEX_BITS-1:0] pick_index();
      if ($urandom_range(3) == 0)
         return INDEX_BITS'($urandom_range(MAX_SIZE - 1));
      return INDEX_BITS'($urandom_range(gen_size - 1));
   endfunction

   task automatic queue_load(input logic [KIND_BITS-1:0] kind, input int row,
                             input int col, input logic signed [INPUT_BITS-1:0] value);
      request_type item;
      item.kind  = kind;
      item.row   = INDEX_BITS'(row);
      item.col   = INDEX_BITS'(col);
      item.value = value;
      pending_items.push_back(item);
      if (kind == KIND_LOAD_A)
         a_loaded[row * MAX_SIZE + col] = 1'b1;
      else if (kind == KIND_LOAD_B)
         b_loaded[row * MAX_SIZE + col] = 1'b1;
   endtask

   // Any cell of the active window never loaded since reset gets a value
   // first; then the compute goes out with junk in its ignored fields.
   task automatic queue_compute();
      for (int i = 0; i < gen_size; i++) begin
         for (int k = 0; k < gen_size; k++) begin
            if (!a_loaded[i * MAX_SIZE + k])
               queue_load(KIND_LOAD_A, i, k, pick_element());
            if (!b_loaded[i * MAX_SIZE + k])
               queue_load(KIND_LOAD_B, i, k, pick_element());
         end
      end
      queue_load(KIND_COMPUTE, $urandom_range(MAX_SIZE - 1),
                 $urandom_range(MAX_SIZE - 1), INPUT_BITS'($urandom));
   endtask

   // load the full active window of both matrices with fixed values
   task automatic fill_window(input logic signed [INPUT_BITS-1:0] a_value,
                              input logic signed [INPUT_BITS-1:0] b_value);
      for (int i = 0; i < gen_size; i++) begin
         for (int k = 0; k < gen_size; k++) begin
            queue_load(KIND_LOAD_A, i, k, a_value);
            queue_load(KIND_LOAD_B, i, k, b_value);
         end
      end
   endtask

   // Size writes only while the block is quiet: all items in, all products
   // out, and a settle time for loads that trail the last compute.
   task automatic change_size(input logic [SIZE_BITS-1:0] setting, input int phase);
      while (pending_items.size() != 0 || expected_products.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      // idle profile: slow receiver first, then slow sender, then full speed
      if (phase < 5) begin
         send_idle_pct = 29;
         recv_idle_pct = 72;
      end else if (phase < 9) begin
         send_idle_pct = 72;
         recv_idle_pct = 29;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      gen_size = effective_size(setting);
      size_changes++;
   endtask

   // Mostly loads with random content, a compute every dozen items or so,
   // and the odd unused kind that should vanish without trace.
   task automatic random_phase(input int target);
      int made;
      int pick;
      made = 0;
      while (made < target) begin
         pick = $urandom_range(99);
         if (pick < 2) begin
            // dropped by the block, not counted
            queue_load(KIND_UNUSED, $urandom_range(MAX_SIZE - 1),
                       $urandom_range(MAX_SIZE - 1), INPUT_BITS'($urandom));
         end else if (pick < 10) begin
            queue_compute();
            made++;
         end else begin
            queue_load((pick < 55) ? KIND_LOAD_A : KIND_LOAD_B, pick_index(),
                       pick_index(), pick_element());
            made++;
         end
      end
      // close every phase on a compute so the stores get read back
      queue_compute();
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // size 0 behaves as 1x1: extremes through a single MAC
      change_size(0, 0);
      queue_load(KIND_LOAD_A, 0, 0, 16'sh8000);
      queue_load(KIND_LOAD_B, 0, 0, 16'sh8000);
      queue_compute();                              // (-2^15)^2
      queue_load(KIND_LOAD_B, 0, 0, 16'sh7fff);
      queue_compute();                              // most negative 1x1
      queue_load(KIND_UNUSED, 0, 0, '0);            // must not clear A[0][0]
      queue_compute();
      queue_load(KIND_LOAD_A, 7, 7, 16'sh7fff);     // far corner, outside window
      queue_load(KIND_LOAD_B, 7, 7, '1);
      queue_load(KIND_LOAD_A, 0, 0, '0);
      queue_compute();

      // 2x2 at the negative extreme, then a mixed-sign tweak
      change_size(2, 1);
      fill_window(16'sh8000, 16'sh8000);
      queue_compute();
      queue_load(KIND_LOAD_A, 0, 1, '1);
      queue_load(KIND_LOAD_B, 1, 0, 16'sh7fff);
      queue_compute();

      for (int p = 0; p < 11; p++) begin
         change_size(phase_sizes[p], p + 2);
         if (phase_sizes[p] == 15) begin
            // clamped to 8: largest positive and most negative 8-term sums
            fill_window(16'sh8000, 16'sh8000);
            queue_compute();
            fill_window(16'sh7fff, 16'sh8000);
            queue_compute();
         end
         random_phase(PHASE_ITEMS);
      end

      while (pending_items.size() != 0 || expected_products.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_products.size() != 0)
         report_mismatch($sformatf("%0d products never came out", expected_products.size()));

      $display("%0d items accepted, %0d product runs, %0d products checked",
               accepted_items, compute_count, checked_results);
      $display("%0d size settings from 0 to 15 under three handshake idle profiles",
               size_changes);
      if (error_count == 0) begin
         $display("square_matrix_multiply regression: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("square_matrix_multiply regression: fail");
      end
      $finish;
   end

endmodule
